[rtl/core/rtfd_pkg.sv]
package rtfd_pkg;

    localparam int PAYLOAD_LEN = 26;
    localparam int SLOT_COUNT  = 3;
    localparam int SLOT_BYTES  = 8;
    localparam int SLOT_BITS   = SLOT_BYTES * 8;

    localparam logic [7:0] HDR_B0  = 8'hAA;
    localparam logic [7:0] HDR_B1  = 8'hFF;
    localparam logic [7:0] HDR_B2  = 8'h03;
    localparam logic [7:0] HDR_B3  = 8'h00;
    localparam logic [7:0] TAIL_B0 = 8'h55;
    localparam logic [7:0] TAIL_B1 = 8'hCC;

    localparam logic [14:0] MAX_FORWARD = 15'd8000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_THR   = 3'd4;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_FF,
        PH_03,
        PH_00,
        PH_PAYLOAD
    } t_phase;

    // Raw slot words of one good frame; byte k of slot s sits at bits [8k+7:8k].
    typedef logic [SLOT_COUNT-1:0][SLOT_BITS-1:0] t_frame;

    typedef struct packed {
        logic [12:0] min_range;
        logic [15:0] max_angle_tan_q8;
        logic [14:0] speed_gate;
        logic [7:0]  hit_threshold;
        logic [7:0]  drop_threshold;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         slot;
        logic               present;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] speed;
        logic [15:0]        resolution;
        logic               last;
    } t_result;

endpackage

[rtl/core/rtfd_fifo.sv]
module rtfd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic                       o_full,
    output logic                       o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr;
    logic [PW-1:0]    n_rd;
    logic [CW-1:0]    n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/core/rtfd_front.sv]
module rtfd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    output logic            o_frame_push,
    output rtfd_pkg::t_frame o_frame
);
    import rtfd_pkg::*;

    localparam logic [4:0] IDX_TAIL0 = 5'(PAYLOAD_LEN - 2);
    localparam logic [4:0] IDX_LAST  = 5'(PAYLOAD_LEN - 1);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [4:0] r_idx;
    logic [4:0] n_idx;
    logic [7:0] r_payload [PAYLOAD_LEN];
    logic       idx_last;

    assign idx_last = (r_idx >= IDX_LAST);

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        if (i_valid) begin
            unique case (r_phase)
                PH_HUNT: begin
                    n_phase = (i_byte == HDR_B0) ? PH_FF : PH_HUNT;
                end
                PH_FF: begin
                    n_phase = (i_byte == HDR_B1) ? PH_03 : PH_HUNT;
                end
                PH_03: begin
                    n_phase = (i_byte == HDR_B2) ? PH_00 : PH_HUNT;
                end
                PH_00: begin
                    if (i_byte == HDR_B3) begin
                        n_phase = PH_PAYLOAD;
                        n_idx   = '0;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_PAYLOAD: begin
                    if (idx_last) begin
                        n_phase = PH_HUNT;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                default: begin
                    n_phase = (i_byte == HDR_B0) ? PH_FF : PH_HUNT;
                end
            endcase
        end
    end

    // The final byte is checked on the fly; the first tail byte is already stored.
    always_comb begin
        o_frame_push = (r_phase == PH_PAYLOAD) && i_valid && idx_last &&
                       (r_payload[IDX_TAIL0] == TAIL_B0) && (i_byte == TAIL_B1);
        for (int s = 0; s < SLOT_COUNT; s++) begin
            for (int k = 0; k < SLOT_BYTES; k++) begin
                o_frame[s][8*k +: 8] = r_payload[s*SLOT_BYTES + k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_idx   <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_phase == PH_PAYLOAD) && i_valid) begin
            r_payload[idx_last ? IDX_LAST : r_idx] <= i_byte;
        end
    end

endmodule

[rtl/core/rtfd_back.sv]
module rtfd_back #(
    parameter int OUT_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rtfd_pkg::t_cfg                 i_cfg,
    input  logic                           i_frame_avail,
    input  rtfd_pkg::t_frame               i_frame,
    output logic                           o_frame_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                           o_res_push,
    output rtfd_pkg::t_result              o_res
);
    import rtfd_pkg::*;

    localparam int CW = $clog2(OUT_DEPTH + 1);
    localparam logic [1:0] SLOT_LAST = 2'(SLOT_COUNT - 1);

    typedef struct packed {
        logic [1:0]         slot;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] sp;
        logic [15:0]        res;
    } t_slot_data;

    // Issue.
    logic [1:0]          r_slot;
    logic                issue;
    logic [CW+1:0]       inflight;
    logic [SLOT_BITS-1:0] w;
    logic [14:0]         mx;
    logic [14:0]         my;
    logic [14:0]         ms;

    // Stage A: decoded fields.
    logic        r_a_valid;
    t_slot_data  r_a_data;
    logic        r_a_nz;
    logic        r_a_ypos;
    logic [14:0] r_a_ax;
    logic [14:0] r_a_my;
    logic [14:0] r_a_ms;

    // Stage B: products and the simple gates.
    logic        r_b_valid;
    t_slot_data  r_b_data;
    logic        r_b_pre;
    logic [14:0] r_b_ax;
    logic [29:0] r_b_ax2;
    logic [29:0] r_b_y2;
    logic [25:0] r_b_mr2;
    logic [30:0] r_b_ytan;

    // Stage C: final gates and persistence.
    logic [7:0]  r_hit  [SLOT_COUNT];
    logic [7:0]  r_drop [SLOT_COUNT];
    logic [30:0] d2;
    logic        det;
    logic [7:0]  hit_cur;
    logic [7:0]  drop_cur;
    logic [7:0]  n_hit;
    logic [7:0]  n_drop;
    logic        pres;

    assign inflight = (CW+2)'(i_out_count) + (CW+2)'(r_a_valid) + (CW+2)'(r_b_valid);
    assign issue    = i_frame_avail && (inflight < (CW+2)'(OUT_DEPTH));
    assign o_frame_pop = issue && (r_slot == SLOT_LAST);

    assign w  = i_frame[r_slot];
    assign mx = w[14:0];
    assign my = w[30:16];
    assign ms = w[46:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= issue;
            r_b_valid <= r_a_valid;
            if (issue) begin
                r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
            end
        end
    end

    // Lateral sign is flipped; forward and speed keep the radar's convention.
    always_ff @(posedge i_clk) begin
        r_a_data.slot <= r_slot;
        r_a_data.x    <= w[15] ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
        r_a_data.y    <= w[31] ? $signed({1'b0, my}) : -$signed({1'b0, my});
        r_a_data.sp   <= w[47] ? $signed({1'b0, ms}) : -$signed({1'b0, ms});
        r_a_data.res  <= w[63:48];
        r_a_nz        <= (w[47:0] != '0);
        r_a_ypos      <= w[31] && (my != '0);
        r_a_ax        <= mx;
        r_a_my        <= my;
        r_a_ms        <= ms;
    end

    always_ff @(posedge i_clk) begin
        r_b_data <= r_a_data;
        r_b_ax   <= r_a_ax;
        r_b_pre  <= r_a_nz && r_a_ypos && (r_a_my <= MAX_FORWARD) &&
                    ((i_cfg.speed_gate == '0) || (r_a_ms <= i_cfg.speed_gate));
        r_b_ax2  <= {15'd0, r_a_ax} * {15'd0, r_a_ax};
        r_b_y2   <= {15'd0, r_a_my} * {15'd0, r_a_my};
        r_b_mr2  <= {13'd0, i_cfg.min_range} * {13'd0, i_cfg.min_range};
        r_b_ytan <= {16'd0, r_a_my} * {15'd0, i_cfg.max_angle_tan_q8};
    end

    always_comb begin
        d2  = {1'b0, r_b_ax2} + {1'b0, r_b_y2};
        det = r_b_pre && !(d2 < {5'd0, r_b_mr2}) &&
              !({8'd0, r_b_ax, 8'd0} > r_b_ytan);
        hit_cur  = r_hit[r_b_data.slot];
        drop_cur = r_drop[r_b_data.slot];
        if (det) begin
            n_drop = '0;
            n_hit  = (hit_cur < i_cfg.hit_threshold) ? hit_cur + 1'b1 : hit_cur;
            pres   = !(n_hit < i_cfg.hit_threshold);
        end else begin
            n_hit  = '0;
            n_drop = (drop_cur < i_cfg.drop_threshold) ? drop_cur + 1'b1 : drop_cur;
            pres   = (n_drop < i_cfg.drop_threshold);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                r_hit[s]  <= '0;
                r_drop[s] <= '0;
            end
        end else if (r_b_valid) begin
            r_hit[r_b_data.slot]  <= n_hit;
            r_drop[r_b_data.slot] <= n_drop;
        end
    end

    assign o_res_push       = r_b_valid;
    assign o_res.slot       = r_b_data.slot;
    assign o_res.present    = pres;
    assign o_res.pos_x      = r_b_data.x;
    assign o_res.pos_y      = r_b_data.y;
    assign o_res.speed      = r_b_data.sp;
    assign o_res.resolution = r_b_data.res;
    assign o_res.last       = (r_b_data.slot == SLOT_LAST);

endmodule

[rtl/core/radar_frame_target_decoder.sv]
// Accepts one byte per cycle while full is low; full rises only while the frame queue holds
// FRAME_DEPTH frames. A good frame yields its slot 0 word after the final tail byte is taken,
// via the frame queue, decode stage, multiply stage and persistence into the result queue.
// Slots 1 and 2 follow in slot order when the result queue has room.
// Synchronous active-low reset empties both queues, restarts header hunting,
// clears the persistence counters and loads the register defaults.
module radar_frame_target_decoder #(
    parameter int FRAME_DEPTH = 2,
    parameter int OUT_DEPTH   = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         i_rx_byte,
    output logic                               empty,
    input  logic                               pop,
    output logic [1:0]                         o_slot,
    output logic                               o_present,
    output logic signed [15:0]                 o_pos_x,
    output logic signed [15:0]                 o_pos_y,
    output logic signed [15:0]                 o_speed,
    output logic [15:0]                        o_resolution,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rtfd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rtfd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import rtfd_pkg::*;

    t_cfg    r_cfg;
    logic    in_take;
    logic    frame_push;
    t_frame  frame_in;
    t_frame  frame_head;
    logic    frame_pop;
    logic    frame_empty;
    logic    res_push;
    t_result res_in;
    t_result res_head;
    logic [$clog2(FRAME_DEPTH+1)-1:0] frame_count;
    logic [$clog2(OUT_DEPTH+1)-1:0]   out_count;
    logic    out_full;

    assign o_cfg_ready = 1'b1;
    assign in_take     = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_range        <= '0;
            r_cfg.max_angle_tan_q8 <= '1;
            r_cfg.speed_gate       <= '0;
            r_cfg.hit_threshold    <= '0;
            r_cfg.drop_threshold   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_RANGE:  r_cfg.min_range        <= i_cfg_data[12:0];
                CFG_MAX_ANGLE:  r_cfg.max_angle_tan_q8 <= i_cfg_data;
                CFG_SPEED_GATE: r_cfg.speed_gate       <= i_cfg_data[14:0];
                CFG_HIT_THR:    r_cfg.hit_threshold    <= i_cfg_data[7:0];
                CFG_DROP_THR:   r_cfg.drop_threshold   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    rtfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_take),
        .i_byte       (i_rx_byte),
        .o_frame_push (frame_push),
        .o_frame      (frame_in)
    );

    rtfd_fifo #(
        .WIDTH ($bits(t_frame)),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (frame_push),
        .i_data  (frame_in),
        .i_pop   (frame_pop),
        .o_data  (frame_head),
        .o_count (frame_count),
        .o_full  (full),
        .o_empty (frame_empty)
    );

    rtfd_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_frame_avail (!frame_empty && (frame_count != '0)),
        .i_frame       (frame_head),
        .o_frame_pop   (frame_pop),
        .i_out_count   (out_count),
        .o_res_push    (res_push),
        .o_res         (res_in)
    );

    rtfd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push && !out_full),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_count (out_count),
        .o_full  (out_full),
        .o_empty (empty)
    );

    assign o_slot       = res_head.slot;
    assign o_present    = res_head.present;
    assign o_pos_x      = res_head.pos_x;
    assign o_pos_y      = res_head.pos_y;
    assign o_speed      = res_head.speed;
    assign o_resolution = res_head.resolution;
    assign o_last       = res_head.last;

endmodule

[rtl/core/rtfd_checker.sv]
module rtfd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_slot,
    input logic       o_last
);

    // Reset drains the result side.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_last_on_third: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last == (o_slot == 2'd2)) && (o_slot != 2'd3))
        else $error("last flag does not match slot index");

    // Words of a frame leave in slot order.
    a_order_after_0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_slot == 2'd0) |=> (empty || o_slot == 2'd1))
        else $error("slot 1 does not follow slot 0");

    a_order_after_1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_slot == 2'd1) |=> (empty || o_slot == 2'd2))
        else $error("slot 2 does not follow slot 1");

endmodule

bind radar_frame_target_decoder rtfd_checker u_rtfd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_slot  (o_slot),
    .o_last  (o_last)
);

[tb/radar_frame_target_decoder_tb.sv]
`timescale 1ns / 100ps

module radar_frame_target_decoder_tb;
    import rtfd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 12;

    typedef enum logic [1:0] {
        POP_ALWAYS,
        POP_MOSTLY,
        POP_RARELY,
        POP_PERIODIC
    } pop_mode_e;

    class frame_scoreboard;
        t_cfg                 cfg;
        t_phase               phase;
        logic [4:0]           byte_pos;
        logic [7:0]           payload [PAYLOAD_LEN];
        logic [7:0]           hits [SLOT_COUNT];
        logic [7:0]           drops [SLOT_COUNT];
        t_result              pending_results [$];
        int                   fails;

        function new();
            cfg.min_range        = '0;
            cfg.max_angle_tan_q8 = 16'hFFFF;
            cfg.speed_gate       = '0;
            cfg.hit_threshold    = '0;
            cfg.drop_threshold   = '0;
            phase     = PH_HUNT;
            byte_pos  = '0;
            fails     = 0;
            foreach (payload[i]) payload[i] = '0;
            foreach (hits[i]) begin
                hits[i]  = '0;
                drops[i] = '0;
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MIN_RANGE:  cfg.min_range        = data[12:0];
                CFG_MAX_ANGLE:  cfg.max_angle_tan_q8 = data;
                CFG_SPEED_GATE: cfg.speed_gate       = data[14:0];
                CFG_HIT_THR:    cfg.hit_threshold    = data[7:0];
                CFG_DROP_THR:   cfg.drop_threshold   = data[7:0];
                default: ;
            endcase
        endfunction

        // The sensor sets bit 15 for a positive value.
        function int sensor_to_int(logic [15:0] w);
            return w[15] ? int'(w[14:0]) : -int'(w[14:0]);
        endfunction

        function t_result decode_slot(int s);
            t_result     r;
            logic [15:0] wx, wy, ws, res;
            int          x, y, sp;
            longint      ax, yl, asp;
            bit          det;
            wx  = {payload[s*SLOT_BYTES+1], payload[s*SLOT_BYTES]};
            wy  = {payload[s*SLOT_BYTES+3], payload[s*SLOT_BYTES+2]};
            ws  = {payload[s*SLOT_BYTES+5], payload[s*SLOT_BYTES+4]};
            res = {payload[s*SLOT_BYTES+7], payload[s*SLOT_BYTES+6]};
            x   = -sensor_to_int(wx);
            y   = sensor_to_int(wy);
            sp  = sensor_to_int(ws);
            ax  = (x < 0) ? -x : x;
            yl  = y;
            asp = (sp < 0) ? -sp : sp;
            det = (wx != 0) || (wy != 0) || (ws != 0);
            if (det && yl <= 0)
                det = 0;
            if (det && ax * ax + yl * yl < longint'(cfg.min_range) * longint'(cfg.min_range))
                det = 0;
            if (det && yl > longint'(MAX_FORWARD))
                det = 0;
            if (det && ax * 256 > yl * longint'(cfg.max_angle_tan_q8))
                det = 0;
            if (det && cfg.speed_gate != 0 && asp > longint'(cfg.speed_gate))
                det = 0;

            if (det) begin
                drops[s] = '0;
                if (hits[s] < cfg.hit_threshold)
                    hits[s]++;
                r.present = !(hits[s] < cfg.hit_threshold);
            end else begin
                hits[s] = '0;
                if (drops[s] < cfg.drop_threshold)
                    drops[s]++;
                r.present = drops[s] < cfg.drop_threshold;
            end
            r.slot       = s[1:0];
            r.pos_x      = x[15:0];
            r.pos_y      = y[15:0];
            r.speed      = sp[15:0];
            r.resolution = res;
            r.last       = (s == SLOT_COUNT - 1);
            return r;
        endfunction

        function void note_byte(logic [7:0] b);
            case (phase)
                PH_FF: phase = (b == HDR_B1) ? PH_03 : PH_HUNT;
                PH_03: phase = (b == HDR_B2) ? PH_00 : PH_HUNT;
                PH_00: begin
                    byte_pos = '0;
                    phase    = (b == HDR_B3) ? PH_PAYLOAD : PH_HUNT;
                end
                PH_PAYLOAD: begin
                    payload[byte_pos] = b;
                    if (byte_pos == PAYLOAD_LEN - 1) begin
                        phase    = PH_HUNT;
                        byte_pos = '0;
                        if (payload[PAYLOAD_LEN-2] == TAIL_B0 && payload[PAYLOAD_LEN-1] == TAIL_B1) begin
                            for (int s = 0; s < SLOT_COUNT; s++) begin
                                pending_results.push_back(decode_slot(s));
                            end
                        end
                    end else begin
                        byte_pos++;
                    end
                end
                default: phase = (b == HDR_B0) ? PH_FF : PH_HUNT;
            endcase
        endfunction

        function void compare_field(string name, int want_v, int got_v);
            if (want_v != got_v) begin
                $error("%s: expected %0d, got %0d", name, want_v, got_v);
                fails++;
            end
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result word for slot %0d arrived with nothing pending", got.slot);
                fails++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("slot", want.slot, got.slot);
            compare_field("present", want.present, got.present);
            compare_field("pos_x", want.pos_x, got.pos_x);
            compare_field("pos_y", want.pos_y, got.pos_y);
            compare_field("speed", want.speed, got.speed);
            compare_field("resolution", want.resolution, got.resolution);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [7:0]            rx_byte = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [1:0]            o_slot;
    logic                  o_present;
    logic signed [15:0]    o_pos_x;
    logic signed [15:0]    o_pos_y;
    logic signed [15:0]    o_speed;
    logic [15:0]           o_resolution;
    logic                  o_last;
    logic                  cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    frame_scoreboard sb = new();

    int        bytes_sent = 0;
    int        burst_left = 0;
    int        idle_cycles = 0;
    int        pop_left = 0;
    int unsigned cyc = 0;
    pop_mode_e pop_mode = POP_ALWAYS;

    radar_frame_target_decoder i_dut (
        .i_clk        (clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_rx_byte    (rx_byte),
        .empty        (empty),
        .pop          (pop),
        .o_slot       (o_slot),
        .o_present    (o_present),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_speed      (o_speed),
        .o_resolution (o_resolution),
        .o_last       (o_last),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: checks each result word and switches between stall patterns.
    always @(posedge clk) begin
        t_result got;
        cyc <= cyc + 1;
        if (i_rst_n && pop && !empty) begin
            got.slot       = o_slot;
            got.present    = o_present;
            got.pos_x      = o_pos_x;
            got.pos_y      = o_pos_y;
            got.speed      = o_speed;
            got.resolution = o_resolution;
            got.last       = o_last;
            sb.check_word(got);
        end
        if (pop_left == 0) begin
            pop_mode <= pop_mode_e'($urandom_range(0, 3));
            pop_left <= $urandom_range(16, 96);
        end else begin
            pop_left <= pop_left - 1;
        end
        case (pop_mode)
            POP_ALWAYS:  pop <= 1'b1;
            POP_MOSTLY:  pop <= ($urandom_range(0, 3) != 0);
            POP_RARELY:  pop <= ($urandom_range(0, 15) == 0);
            default:     pop <= (cyc[3:0] >= 4'd10);
        endcase
    end

    always @(posedge clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [SLOT_BITS-1:0] make_slot(logic [15:0] wx, logic [15:0] wy,
                                                       logic [15:0] ws, logic [15:0] res);
        return {res, ws, wy, wx};
    endfunction

    function automatic logic [7:0] header_byte(int k);
        case (k)
            0:       return HDR_B0;
            1:       return HDR_B1;
            2:       return HDR_B2;
            default: return HDR_B3;
        endcase
    endfunction

    function automatic logic [SLOT_BITS-1:0] random_slot();
        int          pick, ym, xm, sm;
        logic [15:0] wx, wy, ws;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return make_slot('0, '0, '0, 16'($urandom));
        if (pick == 1)
            return {$urandom, $urandom};
        ym = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 8200);
        xm = $urandom_range(0, ym);
        sm = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 400);
        wx = {1'($urandom), 15'(xm)};
        wy = {($urandom_range(0, 7) != 0), 15'(ym)};
        ws = {1'($urandom), 15'(sm)};
        return make_slot(wx, wy, ws, 16'($urandom));
    endfunction

    function automatic t_cfg phase_config(int n);
        t_cfg c;
        case (n)
            0: begin
                c = '{13'd8000, 16'hFFFF, 15'h7FFF, 8'hFF, 8'hFF};
            end
            1: begin
                c = '{13'd0, 16'h0000, 15'd1, 8'h00, 8'h00};
            end
            default: begin
                c.min_range = ($urandom_range(0, 9) == 0) ? 13'd8000 :
                              ($urandom_range(0, 2) == 0) ? 13'd0 : 13'($urandom_range(0, 1500));
                case ($urandom_range(0, 3))
                    0:       c.max_angle_tan_q8 = 16'h0000;
                    1:       c.max_angle_tan_q8 = 16'hFFFF;
                    default: c.max_angle_tan_q8 = 16'($urandom_range(100, 2000));
                endcase
                case ($urandom_range(0, 3))
                    0:       c.speed_gate = 15'h7FFF;
                    1:       c.speed_gate = 15'($urandom_range(1, 500));
                    default: c.speed_gate = '0;
                endcase
                c.hit_threshold  = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 4));
                c.drop_threshold = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 4));
            end
        endcase
        return c;
    endfunction

    // Called on a rising edge; returns on the edge where the word was taken, or later after a burst's idle gap.
    task automatic send_byte(input logic [7:0] b);
        push    <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (full);
        sb.note_byte(b);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 25);
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic send_frame(input logic [SLOT_BITS-1:0] s0, input logic [SLOT_BITS-1:0] s1,
                              input logic [SLOT_BITS-1:0] s2, input logic [7:0] t0,
                              input logic [7:0] t1);
        logic [SLOT_BITS-1:0] slots [SLOT_COUNT];
        slots = '{s0, s1, s2};
        for (int k = 0; k < 4; k++)
            send_byte(header_byte(k));
        for (int s = 0; s < SLOT_COUNT; s++)
            for (int k = 0; k < SLOT_BYTES; k++)
                send_byte(slots[s][8*k +: 8]);
        send_byte(t0);
        send_byte(t1);
    endtask

    // A bad tail produces nothing, so a settle time follows the last result.
    task automatic drain();
        push <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input t_cfg c);
        logic [CFG_IDX_W-1:0]  idx [5];
        logic [CFG_DATA_W-1:0] vals [5];
        idx  = '{CFG_MIN_RANGE, CFG_MAX_ANGLE, CFG_SPEED_GATE, CFG_HIT_THR, CFG_DROP_THR};
        vals = '{16'(c.min_range), c.max_angle_tan_q8, 16'(c.speed_gate),
                 16'(c.hit_threshold), 16'(c.drop_threshold)};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!o_cfg_ready);
            sb.set_register(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sequence();
        int         kind, n;
        logic [7:0] t0, t1, b;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            send_frame(random_slot(), random_slot(), random_slot(), TAIL_B0, TAIL_B1);
        end else if (kind < 80) begin
            t0 = TAIL_B0;
            t1 = TAIL_B1;
            if ($urandom_range(0, 2) != 0)
                t0 = t0 ^ (8'h01 << $urandom_range(0, 7));
            if (t0 == TAIL_B0 || $urandom_range(0, 2) == 0)
                t1 = t1 ^ (8'h01 << $urandom_range(0, 7));
            send_frame(random_slot(), random_slot(), random_slot(), t0, t1);
        end else if (kind < 90) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
                send_byte(header_byte(k));
            b = ($urandom_range(0, 1) == 0) ? HDR_B0 : 8'($urandom);
            if (b == header_byte(n))
                b = ~b;
            send_byte(b);
        end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
    endtask

    initial begin
        int phase_no;
        repeat (3) @(posedge clk);
        i_rst_n <= 1'b1;
        @(posedge clk);

        // Broken headers: a stray AA after AA does not restart the header.
        send_byte(HDR_B0);
        send_byte(HDR_B0);
        send_byte(HDR_B1);
        send_byte(HDR_B2);
        send_byte(HDR_B3);
        send_byte(HDR_B0);
        send_byte(HDR_B1);
        send_byte(HDR_B3);
        send_byte(HDR_B0);
        send_byte(HDR_B1);
        send_byte(HDR_B2);
        send_byte(8'h01);

        // Reset settings: empty slot, far-forward slot, and a target right at the limit.
        send_frame(make_slot(16'h0000, 16'h0000, 16'h0000, 16'hFFFF),
                   make_slot(16'h7FFF, 16'hFFFF, 16'h8000, 16'h0000),
                   make_slot(16'h8000, 16'h9F40, 16'h7FFF, 16'h1234), TAIL_B0, TAIL_B1);
        // Bad tails carry no result and leave persistence alone.
        send_frame(random_slot(), random_slot(), random_slot(), TAIL_B0, 8'hCD);
        send_frame(random_slot(), random_slot(), random_slot(), 8'h54, TAIL_B1);
        // Negative forward, zero forward, and a slot well outside the angle limit.
        send_frame(make_slot(16'h0010, 16'h0064, 16'h0000, 16'h00FF),
                   make_slot(16'h0001, 16'h8000, 16'h8001, 16'hFF00),
                   make_slot(16'hFFFF, 16'h8001, 16'h0000, 16'h5A5A), TAIL_B0, TAIL_B1);
        drain();

        write_config('{13'd1000, 16'd256, 15'd100, 8'd0, 8'd0});
        // Too near, both too near and outside 45 degrees, too fast.
        send_frame(make_slot(16'h0010, 16'h8064, 16'h8000, 16'h0001),
                   make_slot(16'h01F4, 16'h8190, 16'h8000, 16'h0002),
                   make_slot(16'h0000, 16'h8BB8, 16'h80C8, 16'h0003), TAIL_B0, TAIL_B1);

        phase_no = 0;
        while (bytes_sent < 360) begin
            drain();
            write_config(phase_config(phase_no));
            phase_no++;
            repeat ($urandom_range(2, 4)) send_sequence();
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.fails == 0 && sb.pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
